[hdl/base64_stream_decoder_macros.svh]
// Assertion macros shared by the base64 stream decoder modules.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define B64_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("base64 decoder: assertion failed");
// Next-cycle implication, checked out of reset.
`define B64_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("base64 decoder: assertion failed");
`else
`define B64_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define B64_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/b64_pkg.sv]
// Types, constants and the alphabet lookup of the base64 stream decoder.
`timescale 1ns / 1ps

package b64_pkg;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       last_of_message;
    } out_item_t;

    // One decoded group: up to three results, bytes[0] goes out first.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      last_idx;   // index of the final result in this job
        logic            has_data;   // 0: empty end-of-message marker
        logic            last;       // final result closes the message
    } job_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } sextet_t;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    localparam logic [5:0] VAL_LOWER_BASE = 6'd26;
    localparam logic [5:0] VAL_DIGIT_BASE = 6'd52;
    localparam logic [5:0] VAL_PLUS       = 6'd62;
    localparam logic [5:0] VAL_SLASH      = 6'd63;

    localparam logic [1:0] GROUP_FULL = 2'd3;

    // Standard alphabet; '=' and everything else come back not ok.
    function automatic sextet_t sextet_lookup(input logic [7:0] ch);
        sextet_t    res;
        logic [7:0] diff;
        res  = '0;
        diff = '0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            diff    = ch - CH_UPPER_A;
            res.ok  = 1'b1;
            res.val = diff[5:0];
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            diff    = ch - CH_LOWER_A;
            res.ok  = 1'b1;
            res.val = diff[5:0] + VAL_LOWER_BASE;
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            diff    = ch - CH_DIGIT_0;
            res.ok  = 1'b1;
            res.val = diff[5:0] + VAL_DIGIT_BASE;
        end else if (ch == CH_PLUS) begin
            res.ok  = 1'b1;
            res.val = VAL_PLUS;
        end else if (ch == CH_SLASH) begin
            res.ok  = 1'b1;
            res.val = VAL_SLASH;
        end
        return res;
    endfunction

endpackage

[hdl/base64_stream_decoder.sv]
// Top level of the streaming base64 decoder.
`timescale 1ns / 1ps
// Usage:
//   Input channel: one ASCII character per transfer on item.symbol, with
//   item.end_of_text set on the final character of a message. A transfer
//   happens on a rising edge with push high and full low.
//   Result channel: decoded bytes, one per transfer, while empty is low; a
//   transfer happens on a rising edge with pop high. has_data low marks an
//   empty end-of-message result; last_of_message flags the final result.
// Rate: the front end takes one character per cycle while full is low; the
//   back end gives one result per cycle while pop keeps up. Four characters
//   make three bytes. Each job is queued, then walked into the output register.
//   A complete group is one job of three results; the job queue
//   (QUEUE_DEPTH jobs) absorbs that and full rises only when it fills.
// Stall: with pop held low the output register holds its result, the queue
//   fills, then full goes high; nothing is dropped.
// Reset: rst_n clears the group state, the queue and the output valid flag;
//   empty is high and full is low right after reset.
// Decoding stops at '=' or any non-alphabet character; the end flag then
//   flushes the partial group and rearms the decoder.

module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  b64_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output b64_pkg::out_item_t result
);
    import b64_pkg::*;

    logic q_wr;
    logic q_rd;
    logic q_full;
    logic q_empty;
    job_t wr_job;
    job_t head;

    // Front: alphabet lookup, group assembly, job building.
    b64_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .q_full (q_full),
        .q_wr   (q_wr),
        .q_job  (wr_job)
    );

    // Decouples the two halves so each can stall on its own.
    b64_job_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_job  (wr_job),
        .rd_en   (q_rd),
        .head    (head),
        .full    (q_full),
        .q_empty (q_empty)
    );

    // Back: serializes each job into the registered result port.
    b64_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    assign full = q_full;

endmodule

[hdl/b64_front.sv]
// Front end: classifies each character, keeps the group state, builds output jobs.
`timescale 1ns / 1ps

module b64_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64_pkg::in_item_t item,
    input  logic              q_full,
    output logic              q_wr,
    output b64_pkg::job_t     q_job
);
    import b64_pkg::*;

    logic [1:0]  count_reg, count_next;
    logic [17:0] buf_reg, buf_next;
    logic        stopped_reg, stopped_next;

    sextet_t     sx;
    logic        accept;
    logic        take;
    logic        complete;
    logic [1:0]  cnt_upd;
    logic [17:0] buf_upd;
    job_t        job;

    always_comb
    begin
        sx       = sextet_lookup(item.symbol);
        accept   = push && !q_full;
        take     = !stopped_reg && sx.ok;
        complete = take && (count_reg == GROUP_FULL);

        cnt_upd      = count_reg;
        buf_upd      = buf_reg;
        stopped_next = stopped_reg;
        if (complete) begin
            cnt_upd = '0;
            buf_upd = '0;
        end else if (take) begin
            cnt_upd = count_reg + 2'd1;
            buf_upd = {buf_reg[11:0], sx.val};
        end else begin
            stopped_next = 1'b1;
        end

        job          = '0;
        job.last     = item.end_of_text;
        job.has_data = 1'b1;
        q_wr         = 1'b0;
        if (complete) begin
            job.bytes[0] = buf_reg[17:10];
            job.bytes[1] = buf_reg[9:2];
            job.bytes[2] = {buf_reg[1:0], sx.val};
            job.last_idx = 2'd2;
            q_wr         = accept;
        end else if (item.end_of_text) begin
            q_wr = accept;
            unique case (cnt_upd)
                2'd2:
                begin
                    job.bytes[0] = buf_upd[11:4];
                    job.last_idx = 2'd0;
                end
                2'd3:
                begin
                    job.bytes[0] = buf_upd[17:10];
                    job.bytes[1] = buf_upd[9:2];
                    job.last_idx = 2'd1;
                end
                default:
                begin
                    // nothing left to give: empty marker
                    job.has_data = 1'b0;
                    job.last_idx = 2'd0;
                end
            endcase
        end
        q_job = job;

        count_next = count_reg;
        buf_next   = buf_reg;
        if (accept) begin
            if (item.end_of_text) begin
                count_next   = '0;
                buf_next     = '0;
                stopped_next = 1'b0;
            end else begin
                count_next = cnt_upd;
                buf_next   = buf_upd;
            end
        end else begin
            stopped_next = stopped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg   <= '0;
            buf_reg     <= '0;
            stopped_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            buf_reg     <= buf_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

[hdl/b64_job_queue.sv]
// Short job queue between front and back end.
`timescale 1ns / 1ps
`include "base64_stream_decoder_macros.svh"

module b64_job_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  b64_pkg::job_t wr_job,
    input  logic          rd_en,
    output b64_pkg::job_t head,
    output logic          full,
    output logic          q_empty
);
    import b64_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    assign head    = mem_reg[rd_ptr_reg];
    assign full    = (cnt_reg == DEPTH_CNT);
    assign q_empty = (cnt_reg == '0);

    `B64_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, wr_en, !full)
    `B64_ASSERT_IMPLIES(a_no_underflow, clk, rst_n, rd_en, !q_empty)

endmodule

[hdl/b64_back.sv]
// Back end: walks each job one result per cycle into the output register while it is free or popped.
`timescale 1ns / 1ps
`include "base64_stream_decoder_macros.svh"

module b64_back (
    input  logic               clk,
    input  logic               rst_n,
    input  b64_pkg::job_t      head,
    input  logic               q_empty,
    output logic               q_rd,
    input  logic               pop,
    output logic               empty,
    output b64_pkg::out_item_t result
);
    import b64_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;
    logic       load;
    logic       job_done;

    always_comb
    begin
        load     = !q_empty && (!out_valid_reg || pop);
        job_done = (idx_reg == head.last_idx);
        q_rd     = load && job_done;

        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load) begin
            out_next.data_byte       = head.has_data ? head.bytes[idx_reg] : 8'd0;
            out_next.has_data        = head.has_data;
            out_next.last_of_message = head.last && job_done;
            out_valid_next           = 1'b1;
            idx_next                 = job_done ? 2'd0 : idx_reg + 2'd1;
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    `B64_ASSERT_IMPLIES(a_idx_in_job, clk, rst_n, !q_empty, idx_reg <= head.last_idx)
    `B64_ASSERT_IMPLIES(a_marker_is_last, clk, rst_n, out_valid_reg && !out_reg.has_data,
        out_reg.last_of_message && (out_reg.data_byte == 8'd0))

endmodule
